// ===== hw/rtl/pmf_pkg.sv =====
// Shared types and constants for the pattern mask filter.
`timescale 1ns / 1ps

package pmf_pkg;

  localparam int DATA_W    = 8;
  localparam int PAT_BYTES = 32;
  localparam int PAT_WORDS = 4;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int LEN_W     = 6;

  localparam logic [DATA_W-1:0] STAR_BYTE    = 8'h2A;
  localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'h0A;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PAT_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic {
    CMD_DATA,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef logic [PAT_BYTES-1:0][DATA_W-1:0] pat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic busy_flush;
    logic fill_zero;
    logic fill_over;
  } back_status_t;

endpackage

// ===== hw/rtl/pattern_mask_filter.sv =====
// Top level of the pattern mask filter: configuration registers and block wiring.
`timescale 1ns / 1ps

// Channel   Direction  Word contents (lowest bit first)
// s_*       in         tdata: data_byte[7:0]; tuser: flush
// m_*       out        tdata: out_byte[7:0];  tlast: last
// cfg_*     in         index 0-3 pattern bytes (8 per register), 4 pattern length
//
// Steady rate, while neither side stalls, is one word in and one word out per clock;
// the window compare, star and shift are combinational in the window engine.
// A data word that follows a length reduction, or a flush, emits one word per clock,
// while the output is ready, for each held byte it releases (up to the window depth),
// while the input side keeps filling the four-entry queue.
// On its way through, a word passes the input register, the queue and the output register.
// Reset (rst, synchronous) clears the registers and empties queue and window;
// no clearing pass is needed, so words are taken from the first cycle after reset.
// Either side may stall freely: the queue and the output register part them.

module pattern_mask_filter #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pmf_pkg::DATA_W-1:0]    s_tdata,   // data_byte[7:0]
  input  logic                          s_tuser,   // flush
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pmf_pkg::DATA_W-1:0]    m_tdata,   // out_byte[7:0]
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [pmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmf_pkg::CFG_W-1:0]     cfg_wdata
);

  // Effective length never exceeds the window depth or the stored pattern
  localparam int LEN_CAP = (PATTERN_MAX < pmf_pkg::PAT_BYTES) ? PATTERN_MAX
                                                              : pmf_pkg::PAT_BYTES;

  logic [pmf_pkg::PAT_WORDS-1:0][pmf_pkg::CFG_W-1:0] pat_words;
  logic [pmf_pkg::LEN_W-1:0]                         len;
  logic [pmf_pkg::LEN_W-1:0]                         len_raw;

  pmf_pkg::cmd_t            push_item;
  pmf_pkg::cmd_t            q_item;
  pmf_pkg::queue_status_t   q_stat;
  pmf_pkg::back_status_t    bk_stat;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_valid;

  assign len_raw = cfg_wdata[pmf_pkg::LEN_W-1:0];

  // Configuration registers; the user must write them only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_words <= '0;
      len       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pmf_pkg::REG_PAT_0, pmf_pkg::REG_PAT_1,
        pmf_pkg::REG_PAT_2, pmf_pkg::REG_PAT_3: begin
          pat_words[cfg_index[1:0]] <= cfg_wdata;
        end
        pmf_pkg::REG_LEN: begin
          // saturate to the window depth and the stored pattern bytes
          len <= (len_raw > pmf_pkg::LEN_W'(LEN_CAP)) ? pmf_pkg::LEN_W'(LEN_CAP) : len_raw;
        end
        default: begin
          // indexes beyond the register list are dropped
        end
      endcase
    end
  end

  // Front: register and classify incoming words
  pmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_item (push_item)
  );

  // Queue: decouple the front from the window engine
  pmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_stat    (q_stat)
  );

  // Back: window, compare, star and drain through the output register
  pmf_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .pattern  (pmf_pkg::pat_t'(pat_words)),
    .len      (len),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .stat     (bk_stat)
  );

  // The window never holds more bytes than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    !bk_stat.fill_over)
    else $error("window fill beyond depth");

  // A drain in progress always has a byte left to release
  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    bk_stat.busy_flush |-> !bk_stat.fill_zero)
    else $error("flush drain with empty window");

  // The engine only takes commands that are there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // The front only writes when the queue has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

endmodule

// ===== hw/rtl/pmf_front.sv =====
// Input stage: accept stream words, classify them and hand them to the queue.
`timescale 1ns / 1ps

module pmf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [pmf_pkg::DATA_W-1:0]  s_tdata,
  input  logic                        s_tuser,
  input  pmf_pkg::queue_status_t      q_stat,
  output logic                        push,
  output pmf_pkg::cmd_t               push_item
);

  logic          held;
  pmf_pkg::cmd_t cmd;

  assign push      = held && !q_stat.full;
  assign s_tready  = !held || !q_stat.full;
  assign push_item = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      cmd.kind <= s_tuser ? pmf_pkg::CMD_FLUSH : pmf_pkg::CMD_DATA;
      cmd.data <= s_tdata;
    end
  end

endmodule

// ===== hw/rtl/pmf_queue.sv =====
// Short command queue between the input stage and the window engine.
`timescale 1ns / 1ps

module pmf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pmf_pkg::cmd_t          push_item,
  input  logic                   pop,
  output logic                   q_valid,
  output pmf_pkg::cmd_t          q_item,
  output pmf_pkg::queue_status_t q_stat
);

  pmf_pkg::cmd_t                mem [pmf_pkg::QUEUE_DEPTH];
  logic [pmf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pmf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pmf_pkg::QCNT_W-1:0]   count;

  assign q_stat.full  = (count == pmf_pkg::QCNT_W'(pmf_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign q_valid      = !q_stat.empty;
  assign q_item       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + pmf_pkg::QCNT_W'(push) - pmf_pkg::QCNT_W'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/pmf_back.sv =====
// Window engine: append, compare and star, or drain on flush; emit through an output register.
`timescale 1ns / 1ps

module pmf_back #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  pmf_pkg::cmd_t                      q_item,
  output logic                               q_pop,
  input  pmf_pkg::pat_t                      pattern,
  input  logic [pmf_pkg::LEN_W-1:0]          len,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pmf_pkg::DATA_W-1:0]         m_tdata,
  output logic                               m_tlast,
  output pmf_pkg::back_status_t              stat
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_FLUSH
  } state_t;

  state_t                     state;
  state_t                     state_next;
  state_t                     eff;
  logic [pmf_pkg::DATA_W-1:0] win      [PATTERN_MAX];
  logic [pmf_pkg::DATA_W-1:0] win_next [PATTERN_MAX];
  logic [pmf_pkg::DATA_W-1:0] w        [PATTERN_MAX];
  logic [pmf_pkg::DATA_W-1:0] s        [PATTERN_MAX];
  logic [pmf_pkg::DATA_W-1:0] pb       [PATTERN_MAX];
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          fill_next;
  logic [FILL_W-1:0]          f;
  logic [FILL_W-1:0]          f1;
  logic [FILL_W-1:0]          lenf;
  logic                       take;
  logic                       appending;
  logic                       match;
  logic                       cond;
  logic                       can_emit;
  logic                       step;
  logic                       last_next;

  always_comb begin
    take      = (state == ST_IDLE) && q_valid;
    appending = take && (q_item.kind == pmf_pkg::CMD_DATA);
    eff       = state;
    if (take) begin
      eff = (q_item.kind == pmf_pkg::CMD_FLUSH) ? ST_FLUSH : ST_DATA;
    end
    f    = appending ? fill + 1'b1 : fill;
    lenf = FILL_W'(len);

    for (int k = 0; k < PATTERN_MAX; k++) begin
      w[k]  = (appending && (FILL_W'(k) == fill)) ? q_item.data : win[k];
      pb[k] = (k < pmf_pkg::PAT_BYTES) ? pattern[k % pmf_pkg::PAT_BYTES] : '0;
    end

    // Compare of the first len bytes; a newline may only sit at the last compared place
    match = (eff == ST_DATA) && (len != '0);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (FILL_W'(k) < lenf) begin
        if (w[k] != pb[k]) match = 1'b0;
        if ((FILL_W'(k + 1) < lenf) && (w[k] == pmf_pkg::NEWLINE_BYTE)) match = 1'b0;
      end
    end

    for (int k = 0; k < PATTERN_MAX; k++) begin
      s[k] = (match && (FILL_W'(k) < lenf)) ? pmf_pkg::STAR_BYTE : w[k];
    end

    case (eff)
      ST_DATA:  cond = (f != '0) && (f >= lenf);
      ST_FLUSH: cond = (f != '0);
      default:  cond = 1'b0;
    endcase

    can_emit  = !m_tvalid || m_tready;
    step      = cond && can_emit;
    f1        = f - 1'b1;
    last_next = (eff == ST_FLUSH) && (f == FILL_W'(1));

    if (step) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (k < PATTERN_MAX - 1) win_next[k] = s[(k + 1) % PATTERN_MAX];
        else                     win_next[k] = s[k];
      end
      fill_next = f1;
      case (eff)
        ST_DATA:  state_next = ((f1 != '0) && (f1 >= lenf)) ? ST_DATA : ST_IDLE;
        ST_FLUSH: state_next = (f1 != '0) ? ST_FLUSH : ST_IDLE;
        default:  state_next = ST_IDLE;
      endcase
    end else begin
      win_next   = w;
      fill_next  = f;
      state_next = cond ? eff : ST_IDLE;
    end
  end

  assign q_pop           = take;
  assign stat.busy_flush = (state == ST_FLUSH);
  assign stat.fill_zero  = (fill == '0);
  assign stat.fill_over  = (fill > FILL_W'(PATTERN_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      m_tvalid <= step || (m_tvalid && !m_tready);
    end
    win <= win_next;
    if (step) begin
      m_tdata <= s[0];
      m_tlast <= last_next;
    end
  end

endmodule

// ===== tb/tb_pattern_mask_filter.sv =====
// Self-checking testbench for the pattern mask filter: directed cases, then random pattern phases.
`timescale 1ns / 1ps

module tb_pattern_mask_filter;
  import pmf_pkg::*;

  localparam int WINDOW_DEPTH = 32;
  localparam int CYCLE_LIMIT  = 200000;
  // Input register, queue and output register, plus some margin
  localparam int SETTLE_CYCLES = 8;

  localparam logic [CFG_IDX_W-1:0] PAT_REGS [4] = '{REG_PAT_0, REG_PAT_1, REG_PAT_2, REG_PAT_3};

  typedef struct packed {
    logic [DATA_W-1:0] ch;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_LONG_STALL
  } ready_mode_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata   = '0;   // data_byte[7:0]
  logic                 s_tuser   = 1'b0; // flush
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [DATA_W-1:0]    m_tdata;          // out_byte[7:0]
  logic                 m_tlast;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  pattern_mask_filter #(
    .PATTERN_MAX(WINDOW_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the configuration and of the byte window
  pat_t              pat_q   = '0;
  logic [LEN_W-1:0]  pat_len = '0;
  logic [DATA_W-1:0] win_bytes [WINDOW_DEPTH];
  int                win_fill = 0;

  // Masked bytes still owed by the block, oldest first
  out_word_t masked_q[$];
  out_word_t next_want;

  int cycle_count     = 0;
  int mismatches      = 0;
  int words_sent      = 0;
  int flushes_sent    = 0;
  int results_checked = 0;
  int settings_used   = 0;

  // Sender burst state
  int burst_left    = 0;
  bit steady_sender = 1'b0;

  // Receiver stall state
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          run_left   = 0;
  logic        hold_ready = 1'b1;

  // Symbols that the current random phase builds its patterns and text from
  logic [DATA_W-1:0] phase_syms [4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Give up on a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_pattern_mask_filter failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Pattern length in use: the 6-bit register saturated to the window depth
  function automatic int eff_len();
    int n;
    n = int'(pat_len);
    if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
    if (n > PAT_BYTES) n = PAT_BYTES;
    return n;
  endfunction

  // Advance the window by one accepted word and queue the bytes it releases
  function automatic void predict_masking(input logic [DATA_W-1:0] d, input logic fl);
    int        n;
    bit        hit;
    out_word_t w;
    if (fl) begin
      // Drain in order, no compare; mark the final byte
      for (int k = 0; k < win_fill; k++) begin
        w.ch   = win_bytes[k];
        w.last = (k == win_fill - 1);
        masked_q.push_back(w);
      end
      win_fill = 0;
      return;
    end
    n = eff_len();
    if (win_fill < WINDOW_DEPTH) begin
      win_bytes[win_fill] = d;
      win_fill++;
    end
    // After a length cut this loop may release many bytes for one word
    while (win_fill > 0 && win_fill >= n) begin
      if (n > 0) begin
        hit = 1'b1;
        for (int k = 0; k < n; k++) begin
          if (win_bytes[k] != pat_q[k]) hit = 1'b0;
          // A newline may only sit at the last compared position
          if (k + 1 < n && win_bytes[k] == NEWLINE_BYTE) hit = 1'b0;
        end
        if (hit) begin
          for (int k = 0; k < n; k++) win_bytes[k] = STAR_BYTE;
        end
      end
      w.ch   = win_bytes[0];
      w.last = 1'b0;
      masked_q.push_back(w);
      for (int k = 1; k < win_fill; k++) win_bytes[k - 1] = win_bytes[k];
      win_fill--;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one word; when the last burst ran out, open a new one (random gap unless steady)
  task automatic send_word(input logic [DATA_W-1:0] d, input logic fl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_sender ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= fl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_masking(d, fl);
    words_sent++;
    if (fl) flushes_sent++;
  endtask

  // A flush word carries random, ignored data
  task automatic send_flush();
    send_word(DATA_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Hold off the sender, wait for every owed byte, then let the pipeline empty
  task automatic quiesce();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (masked_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PAT_0, REG_PAT_1, REG_PAT_2, REG_PAT_3: pat_q[int'(idx) * 8 +: 8] = val;
      REG_LEN: pat_len = val[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: pick a random stall style and hold it for a random run before picking again
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(40, 250);
    end
    mode_left--;
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_tready <= (cycle_count % 4 == 0);
      READY_LONG_STALL: begin
        if (run_left == 0) begin
          hold_ready = ~hold_ready;
          run_left   = hold_ready ? $urandom_range(1, 3) : $urandom_range(5, 20);
        end
        run_left--;
        m_tready <= hold_ready;
      end
      default: m_tready <= 1'b1;
    endcase
  end

  // Checker: compare each word taken from the block with the oldest owed byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (masked_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word with nothing owed: byte %02h last %0b", $time, m_tdata, m_tlast);
      end else begin
        next_want = masked_q.pop_front();
        results_checked++;
        if (m_tdata !== next_want.ch || m_tlast !== next_want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, next_want.ch, next_want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Length zero: every byte comes straight out; a flush on an empty window gives nothing
  task automatic test_pass_through();
    quiesce();
    write_reg(REG_LEN, '0);
    settings_used++;
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_flush();
  endtask

  // Pattern of the extreme byte values; the flush tags the held byte as last
  task automatic test_match_extremes();
    quiesce();
    write_reg(REG_PAT_0, {48'h0, 8'h00, 8'hFF});
    write_reg(REG_LEN, CFG_W'(2));
    settings_used++;
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_flush();
  endtask

  // Starred bytes stay in the window and take part in the next compare
  task automatic test_star_reuse();
    quiesce();
    write_reg(REG_PAT_0, {48'h0, 8'h62, STAR_BYTE});
    settings_used++;
    send_word(STAR_BYTE, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h62, 1'b0);
    send_flush();
  endtask

  // A match may end on a newline, but a newline earlier in the window blocks it
  task automatic test_newline_rule();
    quiesce();
    write_reg(REG_PAT_0, {48'h0, NEWLINE_BYTE, 8'h61});
    settings_used++;
    send_word(8'h61, 1'b0);
    send_word(NEWLINE_BYTE, 1'b0);
    quiesce();
    write_reg(REG_PAT_0, {48'h0, 8'h61, NEWLINE_BYTE});
    settings_used++;
    send_word(NEWLINE_BYTE, 1'b0);
    send_word(8'h61, 1'b0);
    send_flush();
  endtask

  // Cut the length while bytes are held: the next word releases the backlog
  task automatic test_length_change();
    quiesce();
    write_reg(REG_PAT_0, {32'h0, 32'h64636261});
    write_reg(REG_LEN, CFG_W'(4));
    settings_used++;
    send_word(8'h78, 1'b0);
    send_word(8'h79, 1'b0);
    send_word(8'h7A, 1'b0);
    quiesce();
    write_reg(REG_PAT_0, {56'h0, 8'h79});
    write_reg(REG_LEN, CFG_W'(1));
    settings_used++;
    send_word(8'h71, 1'b0);
    send_flush();
  endtask

  // Length above the window depth saturates; upper write bits are dropped
  task automatic test_length_saturation();
    logic [CFG_W-1:0] junk;
    quiesce();
    junk = {$urandom, $urandom};
    write_reg(REG_LEN, {junk[CFG_W-1:LEN_W], 6'd63});
    settings_used++;
    repeat (5) send_word(DATA_W'($urandom_range(0, 255)), 1'b0);
    send_flush();
  endtask

  // Bias towards the phase alphabet so that matches are common
  function automatic logic [DATA_W-1:0] pick_symbol();
    return phase_syms[$urandom_range(0, 3)];
  endfunction

  // Random phases: each writes every register, then streams pattern copies
  // (some corrupted), noise and flushes. The length-32 phase leaves bytes held in its
  // window so that the following length-1 phase releases a long backlog.
  task automatic test_random_phases();
    int               lens [10] = '{2, 1, 5, 0, 32, 1, 40, 3, 12, 63};
    int               target;
    int               sent;
    int               n;
    int               roll;
    int               bad;
    logic [CFG_W-1:0] val;
    logic [CFG_W-1:0] junk;
    logic [DATA_W-1:0] b;
    for (int p = 0; p < 10; p++) begin
      quiesce();
      steady_sender = ($urandom_range(0, 2) == 0);
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(0, 6))
          0: phase_syms[s] = 8'h00;
          1: phase_syms[s] = 8'hFF;
          2: phase_syms[s] = NEWLINE_BYTE;
          3: phase_syms[s] = STAR_BYTE;
          default: phase_syms[s] = DATA_W'($urandom_range(8'h61, 8'h64));
        endcase
      end
      for (int r = 0; r < 4; r++) begin
        val = {$urandom, $urandom};
        for (int j = 0; j < 8; j++) begin
          if (r * 8 + j < lens[p]) val[j * 8 +: 8] = pick_symbol();
        end
        write_reg(PAT_REGS[r], val);
      end
      junk = {$urandom, $urandom};
      if (lens[p] > WINDOW_DEPTH || $urandom_range(0, 1))
        write_reg(REG_LEN, {junk[CFG_W-1:LEN_W], LEN_W'(lens[p])});
      else
        write_reg(REG_LEN, CFG_W'(lens[p]));
      settings_used++;

      n      = eff_len();
      target = 38;
      sent   = 0;
      while (sent < target) begin
        roll = $urandom_range(0, 99);
        if (n > 0 && roll < 60) begin
          // Pattern copy, one byte in four copies spoilt
          bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
          for (int k = 0; k < n; k++) begin
            b = pat_q[k];
            if (k == bad) b = $urandom_range(0, 1) ? pick_symbol() : DATA_W'($urandom_range(0, 255));
            send_word(b, 1'b0);
            sent++;
          end
        end else if (roll < 66) begin
          send_flush();
          sent++;
        end else begin
          repeat ($urandom_range(1, 3)) begin
            b = ($urandom_range(0, 9) < 7) ? pick_symbol() : DATA_W'($urandom_range(0, 255));
            send_word(b, 1'b0);
            sent++;
          end
        end
      end
      if (lens[p] != WINDOW_DEPTH && $urandom_range(0, 1)) send_flush();
    end
    steady_sender = 1'b0;
    send_flush();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pass_through();
    test_match_extremes();
    test_star_reuse();
    test_newline_rule();
    test_length_change();
    test_length_saturation();
    test_random_phases();

    // Drain, then watch a while for stray words
    quiesce();

    $display("Sent %0d words (%0d flushes) over %0d pattern settings.",
             words_sent, flushes_sent, settings_used);
    $display("Checked %0d output words, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_pattern_mask_filter passed");
    end else begin
      $display("tb_pattern_mask_filter failed");
    end
    $finish;
  end

endmodule
